/* design/vc1scp_pkg.sv */
`default_nettype none
package vc1scp_pkg;

   // Start code prefix as it sits in the three-byte window
   localparam logic [23:0] START_PREFIX  = 24'h000001;
   localparam logic [7:0]  SUFFIX_LIMIT  = 8'h20;

   // Start code suffixes
   localparam logic [7:0]  SC_SEQ_HDR    = 8'h0F;
   localparam logic [7:0]  SC_ENTRY      = 8'h0E;
   localparam logic [7:0]  SC_FRAME      = 8'h0D;
   localparam logic [7:0]  SC_FIELD      = 8'h0C;
   localparam logic [7:0]  SC_SLICE      = 8'h0B;

   // Sequence header check byte
   localparam logic [1:0]  PROFILE_ADV   = 2'd3;
   localparam logic [2:0]  LEVEL_LIMIT   = 3'd5;
   localparam logic [1:0]  CHROMA_420    = 2'd1;

   // Scan positions to skip
   localparam logic [3:0]  SKIP_CODE     = 4'd4;
   localparam logic [3:0]  SKIP_ENTRY    = 4'd6;
   localparam logic [3:0]  SKIP_SEQ_ADD  = 4'd6;

   localparam logic [1:0]  FILL_FULL     = 2'd3;

   // Result classes
   localparam logic [1:0]  CLASS_NONE    = 2'd0;
   localparam logic [1:0]  CLASS_WEAK    = 2'd1;
   localparam logic [1:0]  CLASS_STRONG  = 2'd2;

   localparam int          OUT_BITS      = 16;
   localparam logic [15:0] OUT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic done;            // last byte transferred this cycle
      logic header_pending;  // sequence header still waits for its check byte
   } scan_flags_type;

endpackage
`default_nettype wire

/* design/vc1_start_code_probe.sv */
// Channel   Ports                                            Direction
// req       req_valid, req_ready, req_data_byte, req_last_byte   in
// rsp       rsp_valid, rsp_ready, rsp_score_class,
//           rsp_frames_seen, rsp_invalid_seen                    out
//
// One byte per cycle unless stalled; a result shows the cycle after its last byte.
// Scan state updates in one pass from the scanner registers; the result register
// holds the final counts and class.
// Reset (synchronous) clears scan state and result valid; a last byte clears scan state.
// A stalled result blocks only a further last byte; other bytes keep flowing.
`default_nettype none
module vc1_start_code_probe #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [1:0]  rsp_score_class,
   output logic      [15:0] rsp_frames_seen,
   output logic      [15:0] rsp_invalid_seen
);
   import vc1scp_pkg::*;

   scan_flags_type        flags;
   logic [COUNT_BITS-1:0] frames_out;
   logic [COUNT_BITS-1:0] invalid_out;
   logic                  take;

   // hold a last byte while the previous result waits
   assign req_ready = !rsp_valid || rsp_ready || !req_last_byte;
   assign take      = req_valid && req_ready;

   vc1scp_scanner #(.COUNT_BITS(COUNT_BITS)) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .flags       (flags),
      .frames_out  (frames_out),
      .invalid_out (invalid_out)
   );

   vc1scp_result #(.COUNT_BITS(COUNT_BITS)) u_result (
      .clock            (clock),
      .reset            (reset),
      .flags            (flags),
      .frames_out       (frames_out),
      .invalid_out      (invalid_out),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_score_class  (rsp_score_class),
      .rsp_frames_seen  (rsp_frames_seen),
      .rsp_invalid_seen (rsp_invalid_seen)
   );

endmodule
`default_nettype wire

/* design/vc1scp_scanner.sv */
`default_nettype none
module vc1scp_scanner #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [7:0]                 data_byte,
   input  wire logic                       last_byte,
   output vc1scp_pkg::scan_flags_type      flags,
   output logic      [COUNT_BITS-1:0]      frames_out,
   output logic      [COUNT_BITS-1:0]      invalid_out
);
   import vc1scp_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [23:0]           window_ff,  window_in;
   logic [3:0]            skip_ff,    skip_in;
   logic                  pending_ff, pending_in;
   logic [1:0]            fill_ff,    fill_in;
   logic [COUNT_BITS-1:0] seq_ff,     seq_in;
   logic [COUNT_BITS-1:0] entry_ff,   entry_in;
   logic [COUNT_BITS-1:0] frame_ff,   frame_in;
   logic [COUNT_BITS-1:0] invalid_ff, invalid_in;

   logic check_ok;
   logic code_hit;

   assign check_ok = (data_byte[7:6] == PROFILE_ADV) && (data_byte[5:3] < LEVEL_LIMIT)
                     && (data_byte[2:1] == CHROMA_420);
   assign code_hit = (fill_ff == FILL_FULL) && (window_ff == START_PREFIX)
                     && (data_byte < SUFFIX_LIMIT);

   always_comb begin
      seq_in     = seq_ff;
      entry_in   = entry_ff;
      frame_in   = frame_ff;
      invalid_in = invalid_ff;
      skip_in    = skip_ff;
      pending_in = 1'b0;

      // check byte of a sequence header
      if (pending_ff) begin
         if (check_ok) begin
            seq_in  = (seq_ff == CNT_MAX) ? CNT_MAX : seq_ff + 1'b1;
            skip_in = skip_ff + SKIP_SEQ_ADD;
         end else begin
            seq_in     = '0;
            invalid_in = (invalid_ff == CNT_MAX) ? CNT_MAX : invalid_ff + 1'b1;
         end
      end

      if (skip_in != 4'd0) begin
         skip_in = skip_in - 1'b1;
      end else if (code_hit) begin
         skip_in = SKIP_CODE;
         case (data_byte)
            SC_SEQ_HDR: begin
               pending_in = 1'b1;
            end
            SC_ENTRY: begin
               if (seq_in == '0) begin
                  invalid_in = (invalid_in == CNT_MAX) ? CNT_MAX : invalid_in + 1'b1;
               end else begin
                  entry_in = (entry_ff == CNT_MAX) ? CNT_MAX : entry_ff + 1'b1;
                  skip_in  = SKIP_ENTRY;
               end
            end
            SC_FRAME, SC_FIELD, SC_SLICE: begin
               if (seq_in != '0 && entry_ff != '0) begin
                  frame_in = (frame_ff == CNT_MAX) ? CNT_MAX : frame_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      window_in = {window_ff[15:0], data_byte};
      fill_in   = (fill_ff == FILL_FULL) ? FILL_FULL : fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         window_ff  <= '0;
         skip_ff    <= '0;
         pending_ff <= 1'b0;
         fill_ff    <= '0;
         seq_ff     <= '0;
         entry_ff   <= '0;
         frame_ff   <= '0;
         invalid_ff <= '0;
      end else if (take) begin
         window_ff  <= window_in;
         skip_ff    <= skip_in;
         pending_ff <= pending_in;
         fill_ff    <= fill_in;
         seq_ff     <= seq_in;
         entry_ff   <= entry_in;
         frame_ff   <= frame_in;
         invalid_ff <= invalid_in;
      end
   end

   // Padding zeros only matter through a header still waiting for its check byte
   assign flags.done           = take && last_byte;
   assign flags.header_pending = pending_in;
   assign frames_out           = frame_in;
   assign invalid_out          = invalid_in;

endmodule
`default_nettype wire

/* design/vc1scp_result.sv */
`default_nettype none
module vc1scp_result #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire vc1scp_pkg::scan_flags_type flags,
   input  wire logic [COUNT_BITS-1:0]      frames_out,
   input  wire logic [COUNT_BITS-1:0]      invalid_out,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic      [1:0]                 rsp_score_class,
   output logic      [15:0]                rsp_frames_seen,
   output logic      [15:0]                rsp_invalid_seen
);
   import vc1scp_pkg::*;

   localparam int WIDE = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic                  valid_ff;
   logic [1:0]            class_ff,   class_in;
   logic [15:0]           frames_ff,  frames_in;
   logic [15:0]           invalid_ff, invalid_in;
   logic [COUNT_BITS-1:0] inv_final;
   logic [WIDE-1:0]       frames_wide;
   logic [WIDE-1:0]       inv_wide;

   always_comb begin
      // first padding byte fails a pending header check
      inv_final = invalid_out;
      if (flags.header_pending && invalid_out != CNT_MAX) begin
         inv_final = invalid_out + 1'b1;
      end

      if (frames_out > COUNT_BITS'(1) && (frames_out >> 1) > inv_final) begin
         class_in = CLASS_STRONG;
      end else if (frames_out != '0) begin
         class_in = CLASS_WEAK;
      end else begin
         class_in = CLASS_NONE;
      end

      frames_wide = WIDE'(frames_out);
      inv_wide    = WIDE'(inv_final);
      frames_in   = (frames_wide > WIDE'(OUT_MAX)) ? OUT_MAX : frames_wide[15:0];
      invalid_in  = (inv_wide > WIDE'(OUT_MAX)) ? OUT_MAX : inv_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (flags.done) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (flags.done) begin
         class_ff   <= class_in;
         frames_ff  <= frames_in;
         invalid_ff <= invalid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_score_class  = class_ff;
   assign rsp_frames_seen  = frames_ff;
   assign rsp_invalid_seen = invalid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      flags.done |-> !(valid_ff && !rsp_ready))
      else $error("result overwritten while still waiting");

   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      flags.done |=> valid_ff)
      else $error("final byte gave no result");

   a_class_none: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((class_ff == CLASS_NONE) == (frames_ff == 16'd0)))
      else $error("class disagrees with frame count");

   a_class_strong: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && class_ff == CLASS_STRONG) |-> (frames_ff > 16'd1))
      else $error("strong class with too few frames");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import vc1scp_pkg::*;

   localparam int        IDLE_LIMIT = 2000;
   localparam int        HOLD_CYCLES = 300;
   localparam int        CODE_REPEATS = 10;
   localparam logic [7:0] P0 = START_PREFIX[23:16];
   localparam logic [7:0] P1 = START_PREFIX[15:8];
   localparam logic [7:0] P2 = START_PREFIX[7:0];
   localparam logic [7:0] PAD = 8'h5A;
   localparam logic [15:0] COUNT_MAX = OUT_MAX;
   localparam logic [7:0] SC_SUFFIX_TOP = SUFFIX_LIMIT - 8'd1;

   typedef struct packed {
      logic [1:0]  score_class;
      logic [15:0] frames_seen;
      logic [15:0] invalid_seen;
   } score_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_score_class;
   logic [15:0] rsp_frames_seen;
   logic [15:0] rsp_invalid_seen;

   // scanner state as the block should hold it
   logic [23:0] scan_window;
   logic [3:0]  scan_skip;
   logic        scan_hdr_wait;
   logic [1:0]  scan_fill;
   logic [15:0] seq_total;
   logic [15:0] entry_total;
   logic [15:0] frame_total;
   logic [15:0] invalid_total;

   score_type   pending_scores[$];
   logic [7:0]  draft[$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   int          hold_requests = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   bit          tx_idle_on = 1'b0;
   bit          rx_idle_on = 1'b0;

   vc1_start_code_probe dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_score_class  (rsp_score_class),
      .rsp_frames_seen  (rsp_frames_seen),
      .rsp_invalid_seen (rsp_invalid_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   function automatic void clear_scan();
      scan_window   = '0;
      scan_skip     = '0;
      scan_hdr_wait = 1'b0;
      scan_fill     = '0;
      seq_total     = '0;
      entry_total   = '0;
      frame_total   = '0;
      invalid_total = '0;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      if (scan_hdr_wait) begin
         scan_hdr_wait = 1'b0;
         if (b[7:6] == PROFILE_ADV && b[5:3] < LEVEL_LIMIT && b[2:1] == CHROMA_420) begin
            seq_total = sat_inc(seq_total);
            scan_skip = scan_skip + SKIP_SEQ_ADD;
         end else begin
            seq_total     = '0;
            invalid_total = sat_inc(invalid_total);
         end
      end
      if (scan_skip != 0) begin
         scan_skip = scan_skip - 4'd1;
      end else if (scan_fill == FILL_FULL && scan_window == START_PREFIX &&
                   b < SUFFIX_LIMIT) begin
         scan_skip = SKIP_CODE;
         case (b)
            SC_SEQ_HDR: begin
               scan_hdr_wait = 1'b1;
            end
            SC_ENTRY: begin
               if (seq_total == 0) begin
                  invalid_total = sat_inc(invalid_total);
               end else begin
                  entry_total = sat_inc(entry_total);
                  scan_skip   = SKIP_ENTRY;
               end
            end
            SC_FRAME, SC_FIELD, SC_SLICE: begin
               if (seq_total != 0 && entry_total != 0)
                  frame_total = sat_inc(frame_total);
            end
            default: ;
         endcase
      end
      scan_window = {scan_window[15:0], b};
      if (scan_fill != FILL_FULL)
         scan_fill = scan_fill + 2'd1;
   endfunction

   // pad with four zero bytes, grade the buffer and start afresh
   function automatic score_type close_buffer();
      score_type s;
      repeat (4) scan_byte(8'h00);
      if (frame_total > 1 && (frame_total >> 1) > invalid_total)
         s.score_class = CLASS_STRONG;
      else if (frame_total >= 1)
         s.score_class = CLASS_WEAK;
      else
         s.score_class = CLASS_NONE;
      s.frames_seen  = frame_total;
      s.invalid_seen = invalid_total;
      clear_scan();
      return s;
   endfunction

   always @(posedge clock) begin : scoreboard
      score_type want;
      if (reset) begin
         clear_scan();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_scores.size() == 0) begin
               $error("result with nothing outstanding: class %0d frames %0d invalid %0d",
                      rsp_score_class, rsp_frames_seen, rsp_invalid_seen);
               fail_count++;
            end else begin
               want = pending_scores.pop_front();
               if (rsp_score_class !== want.score_class) begin
                  $error("score_class: expected %0d, got %0d", want.score_class,
                         rsp_score_class);
                  fail_count++;
               end
               if (rsp_frames_seen !== want.frames_seen) begin
                  $error("frames_seen: expected %0d, got %0d", want.frames_seen,
                         rsp_frames_seen);
                  fail_count++;
               end
               if (rsp_invalid_seen !== want.invalid_seen) begin
                  $error("invalid_seen: expected %0d, got %0d", want.invalid_seen,
                         rsp_invalid_seen);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            scan_byte(req_data_byte);
            if (req_last_byte)
               pending_scores.push_back(close_buffer());
         end
      end
   end

   // result side: long hold on request, otherwise random stall bursts
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (tx_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_buffer();
      foreach (draft[i])
         send_byte(draft[i], i == draft.size() - 1);
   endtask

   // hold the sender until every outstanding result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic void add_code(input logic [7:0] suffix);
      draft.push_back(P0);
      draft.push_back(P1);
      draft.push_back(P2);
      draft.push_back(suffix);
   endfunction

   function automatic void add_filler(input int count);
      repeat (count)
         draft.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
   endfunction

   // mostly well-formed code sequences with random content, some noise
   function automatic void build_random_buffer();
      logic [7:0] pick;
      draft = {};
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom));
         return;
      end
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               add_code(SC_SEQ_HDR);
               if ($urandom_range(0, 3) != 0)
                  draft.push_back({PROFILE_ADV, 3'($urandom_range(0, 4)), CHROMA_420,
                                   1'($urandom)});
               else
                  draft.push_back(8'($urandom));
            end
            2: add_code(SC_ENTRY);
            3, 4, 5: begin
               case ($urandom_range(0, 2))
                  0: pick = SC_FRAME;
                  1: pick = SC_FIELD;
                  default: pick = SC_SLICE;
               endcase
               add_code(pick);
            end
            6: add_code(8'($urandom_range(0, 31)));
            7: add_code(8'($urandom_range(32, 255)));
            8: begin
               draft.push_back(P0);
               draft.push_back(P0);
               draft.push_back(8'($urandom_range(2, 255)));
               draft.push_back(8'($urandom_range(0, 31)));
            end
            default: begin
               repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom));
            end
         endcase
         add_filler($urandom_range(0, 10));
      end
   endfunction

   task automatic test_short_buffers();
      draft = {8'h00};
      send_buffer();
      draft = {8'hFF, 8'hFF};
      send_buffer();
      // a prefix tail at the very start must not match
      draft = {P2, SC_FRAME};
      send_buffer();
      // header on the last byte: its check byte is padding
      draft = {};
      add_code(SC_SEQ_HDR);
      send_buffer();
      draft = {};
      add_code(SC_ENTRY);
      send_buffer();
      wait_drain();
   endtask

   task automatic test_header_checks();
      draft = {};
      add_code(SC_SEQ_HDR);
      draft.push_back({PROFILE_ADV, LEVEL_LIMIT, CHROMA_420, 1'b0});
      add_code(SC_SEQ_HDR);
      draft.push_back({PROFILE_ADV, 3'd4, 2'd0, 1'b1});
      add_code(SC_SEQ_HDR);
      draft.push_back({2'd1, 3'd0, CHROMA_420, 1'b0});
      add_code(SC_SUFFIX_TOP);
      add_code(SUFFIX_LIMIT);
      send_buffer();
      wait_drain();
   endtask

   task automatic test_full_sequence();
      draft = {};
      add_code(SC_SEQ_HDR);
      draft.push_back({PROFILE_ADV, 3'd0, CHROMA_420, 1'b1});
      repeat (5) draft.push_back(PAD);
      add_code(SC_ENTRY);
      repeat (2) draft.push_back(PAD);
      add_code(SC_FRAME);
      draft.push_back(PAD);
      add_code(SC_FIELD);
      draft.push_back(PAD);
      add_code(SC_SLICE);
      send_buffer();
      wait_drain();
   endtask

   // repeat entry and frame codes many times in one buffer
   task automatic test_repeated_codes();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      draft = {};
      add_code(SC_ENTRY);
      send_buffer_open();
      repeat (CODE_REPEATS) begin
         send_byte(PAD, 1'b0);
         send_byte(P0, 1'b0);
         send_byte(P1, 1'b0);
         send_byte(P2, 1'b0);
         send_byte(SC_ENTRY, 1'b0);
      end
      draft = {PAD};
      add_code(SC_SEQ_HDR);
      draft.push_back({PROFILE_ADV, 3'd2, CHROMA_420, 1'b0});
      repeat (5) draft.push_back(PAD);
      add_code(SC_ENTRY);
      repeat (2) draft.push_back(PAD);
      add_code(SC_FRAME);
      send_buffer_open();
      repeat (CODE_REPEATS) begin
         send_byte(PAD, 1'b0);
         send_byte(P0, 1'b0);
         send_byte(P1, 1'b0);
         send_byte(P2, 1'b0);
         send_byte(SC_FRAME, 1'b0);
      end
      send_byte(PAD, 1'b1);
      wait_drain();
   endtask

   // send the draft without closing the buffer
   task automatic send_buffer_open();
      foreach (draft[i])
         send_byte(draft[i], 1'b0);
   endtask

   task automatic run_random(input int min_bytes, input int min_buffers, input bit gaps);
      int start_bytes;
      int buffers;
      start_bytes = bytes_sent;
      buffers = 0;
      while (bytes_sent - start_bytes < min_bytes || buffers < min_buffers) begin
         tx_idle_on = gaps && ($urandom_range(0, 3) != 0);
         rx_idle_on = gaps && ($urandom_range(0, 3) != 0);
         build_random_buffer();
         send_buffer();
         buffers++;
      end
      wait_drain();
   endtask

   task automatic test_random_buffers();
      run_random(900, 20, 1'b1);
   endtask

   // stall the result side while short buffers keep coming
   task automatic test_output_backpressure();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_requests++;
      repeat (12) begin
         draft = {};
         add_filler($urandom_range(1, 3));
         add_code(SC_FRAME);
         send_buffer();
      end
      wait_drain();
   endtask

   task automatic test_streaming_no_gaps();
      run_random(300, 8, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_buffers();
      test_header_checks();
      test_full_sequence();
      test_repeated_codes();
      test_random_buffers();
      test_output_backpressure();
      test_streaming_no_gaps();
      wait_drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
